### src/grmc_pkg.sv
// ----------------------------------------------------------------------------
// grmc_pkg: grid ray march column shared definitions
// Constants, codes and elaboration-time tables (quarter-wave sine, wall top)
// used by the column ray caster.
// ----------------------------------------------------------------------------
`default_nettype none

package grmc_pkg;

  typedef longint unsigned u64_t;

  // screen and march geometry
  localparam int SCREEN_WIDTH    = 250;
  localparam int SCREEN_HEIGHT   = 120;
  localparam int MARCH_STEPS     = 60;
  localparam int SINE_TABLE_SIZE = 1024;

  // field widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COLUMN_W   = 8;
  localparam int CELL_W     = 8;
  localparam int FOV_W      = 15;
  localparam int ANGLE_W    = 16;
  localparam int POS_W      = 16;
  localparam int HIT_W      = 6;
  localparam int TOP_W      = 11;
  localparam int BOTTOM_W   = 10;
  localparam int SHADE_W    = 2;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_ANGLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD      = 2'd3;

  localparam logic [POS_W-1:0]   PLAYER_X_RESET   = 16'd32768;
  localparam logic [POS_W-1:0]   PLAYER_Y_RESET   = 16'd32768;
  localparam logic [ANGLE_W-1:0] VIEW_ANGLE_RESET = 16'd0;
  localparam logic [FOV_W-1:0]   FIELD_RESET      = 15'd9387;

  // shade codes
  localparam logic [SHADE_W-1:0] SHADE_NEAR = 2'd0;
  localparam logic [SHADE_W-1:0] SHADE_MID  = 2'd1;
  localparam logic [SHADE_W-1:0] SHADE_FAR  = 2'd2;
  localparam int SHADE_MID_STEPS = 20;
  localparam int SHADE_FAR_STEPS = 40;

  // sine table, Q1.14
  localparam int SINE_IDX_W   = $clog2(SINE_TABLE_SIZE);
  localparam int QUARTER_SIZE = SINE_TABLE_SIZE / 4;
  localparam int QUARTER_W    = SINE_IDX_W - 2;
  localparam int ONE_Q14      = 16384;
  localparam int MAG_W        = 15;
  localparam int TRIG_W       = MAG_W + 1;
  localparam u64_t PI_Q28     = 64'd843314857;

  // column offset: (column * fov) / SCREEN_WIDTH by reciprocal
  localparam int   COL_PROD_W  = COLUMN_W + FOV_W;
  localparam int   COL_SHIFT   = COL_PROD_W + 8;
  localparam u64_t COL_RECIP   = ((64'd1 << COL_SHIFT) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
  localparam int   COL_RECIP_W = 24;

  // floor division of a Q1.14 direction by the step divisor
  localparam int STEP_DIV      = 20;
  localparam int STEP_BIAS_Q   = ONE_Q14 / STEP_DIV + 1;
  localparam int STEP_BIAS     = STEP_BIAS_Q * STEP_DIV;
  localparam int STEP_N_W      = 16;
  localparam int STEP_SHIFT    = STEP_N_W + 5;
  localparam int STEP_RECIP    = ((1 << STEP_SHIFT) + STEP_DIV - 1) / STEP_DIV;
  localparam int STEP_RECIP_W  = 17;
  localparam int STEP_PROD_W   = STEP_N_W + STEP_RECIP_W;
  localparam int QD_W          = STEP_PROD_W - STEP_SHIFT;
  localparam int REM_W         = $clog2(STEP_DIV);

  // march accumulators and positions
  localparam int STEP_W   = $clog2(MARCH_STEPS + 3);
  localparam int KW       = $clog2(MARCH_STEPS + 1);
  localparam int QW       = $clog2(((MARCH_STEPS + 2) * ONE_Q14) / STEP_DIV + 2) + 1;
  localparam int POS_FRAC = 12;
  localparam int XW       = ((QW > POS_W + 1) ? QW : POS_W + 1) + 3;
  localparam int TXW      = XW - POS_FRAC;

  typedef logic [QUARTER_SIZE-1:0][MAG_W-1:0] sine_rom_t;
  typedef logic [MARCH_STEPS:0][TOP_W-1:0]    top_rom_t;

  function automatic logic [MAG_W-1:0] quarter_sine(int j);
    u64_t   r;
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    longint sum;
    longint q;
    r    = (u64_t'(j) << 22) / QUARTER_SIZE;
    x    = (r * PI_Q28) >> 23;
    x2   = (x * x) >> 28;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 28) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 28) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 28) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 28) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 28) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 28) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 8192) >>> 14;
    if (q > ONE_Q14) begin
      q = ONE_Q14;
    end
    return MAG_W'(q);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int j = 0; j < QUARTER_SIZE; j++) begin
      rom[j] = quarter_sine(j);
    end
    return rom;
  endfunction

  // trunc((H/2*k - 5*H) / k) by long division
  function automatic logic [TOP_W-1:0] wall_top_of(int k);
    int numer;
    int mag;
    int quo;
    int rem;
    numer = (SCREEN_HEIGHT / 2) * k - 5 * SCREEN_HEIGHT;
    mag   = (numer < 0) ? -numer : numer;
    quo   = 0;
    rem   = 0;
    if (k > 0) begin
      for (int b = 23; b >= 0; b--) begin
        rem = (rem << 1) | ((mag >> b) & 1);
        if (rem >= k) begin
          rem = rem - k;
          quo = quo | (1 << b);
        end
      end
    end
    if (numer < 0) begin
      quo = -quo;
    end
    return TOP_W'(quo);
  endfunction

  function automatic top_rom_t build_top_rom();
    top_rom_t rom;
    for (int k = 0; k <= MARCH_STEPS; k++) begin
      rom[k] = wall_top_of(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM     = build_sine_rom();
  localparam top_rom_t  WALL_TOP_ROM = build_top_rom();

endpackage

`default_nettype wire

### src/grmc_ram.sv
// ----------------------------------------------------------------------------
// grmc_ram: generic single-port RAM
// One write or read address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module grmc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### src/grid_ray_march_column.sv
// ----------------------------------------------------------------------------
// grid_ray_march_column: pseudo-3D grid ray caster, one screen column per cast
//
//   channel  handshake              payload
//   cfg      cfg_write              cfg_index, cfg_data
//   in       in_valid / in_stall    cmd, cell_index, cell_is_wall, column
//   out      out_valid / out_stall  out_column, hit_steps, hit_found,
//                                   wall_top, wall_bottom, shade
//
// A map write is done without leaving the idle state; a cast steps through the
// angle, sine, split, seed, march and finish states, taking k steps (at most 60),
// and the march reads one map cell per cycle through the single port of the map RAM.
// After reset all MAP_WIDTH*MAP_HEIGHT cells (192 by default) are swept to open
// floor with in_stall high; config writes are taken throughout.
// A result waits in the output register while the next item is taken; a
// finished cast holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_march_column #(
  parameter int MAP_WIDTH  = 16,
  parameter int MAP_HEIGHT = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [grmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [grmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [grmc_pkg::CELL_W-1:0]        cell_index,
  input  logic                               cell_is_wall,
  input  logic [grmc_pkg::COLUMN_W-1:0]      column,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [grmc_pkg::COLUMN_W-1:0]      out_column,
  output logic [grmc_pkg::HIT_W-1:0]         hit_steps,
  output logic                               hit_found,
  output logic signed [grmc_pkg::TOP_W-1:0]  wall_top,
  output logic [grmc_pkg::BOTTOM_W-1:0]      wall_bottom,
  output logic [grmc_pkg::SHADE_W-1:0]       shade
);

  import grmc_pkg::*;

  localparam int CELL_COUNT = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int MXW        = $clog2(MAP_WIDTH);
  localparam int MYW        = $clog2(MAP_HEIGHT);
  localparam int ANG_PROD_W = COL_PROD_W + COL_RECIP_W;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_ANGLE  = 8'b0000_0100,
    S_SINE   = 8'b0000_1000,
    S_SPLIT  = 8'b0001_0000,
    S_SEED   = 8'b0010_0000,
    S_MARCH  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  function automatic logic signed [TRIG_W-1:0] trig_lookup(logic [SINE_IDX_W-1:0] idx);
    logic [1:0]           quad;
    logic [QUARTER_W-1:0] low;
    logic [MAG_W-1:0]     mag;
    quad = idx[SINE_IDX_W-1 -: 2];
    low  = idx[QUARTER_W-1:0];
    if (quad[0] && low == '0) begin
      mag = MAG_W'(ONE_Q14);
    end else if (quad[0]) begin
      mag = SINE_ROM[QUARTER_W'(QUARTER_SIZE - int'(low))];
    end else begin
      mag = SINE_ROM[low];
    end
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  state_t state;
  state_t state_next;

  logic [AW-1:0]      clr_addr;
  logic [POS_W-1:0]   player_x;
  logic [POS_W-1:0]   player_y;
  logic [ANGLE_W-1:0] view_angle;
  logic [FOV_W-1:0]   field_of_view;

  logic [COLUMN_W-1:0]   col;
  logic [COL_PROD_W-1:0] col_prod;
  logic [ANGLE_W-1:0]    ang_off;
  logic signed [TRIG_W-1:0] ex;
  logic signed [TRIG_W-1:0] ey;
  logic [STEP_N_W-1:0]    n_x;
  logic [STEP_N_W-1:0]    n_y;
  logic [STEP_PROD_W-1:0] prod_x;
  logic [STEP_PROD_W-1:0] prod_y;
  logic signed [QW-1:0]   eq_x;
  logic signed [QW-1:0]   eq_y;
  logic [REM_W-1:0]       er_x;
  logic [REM_W-1:0]       er_y;
  logic signed [QW-1:0]   q_x;
  logic signed [QW-1:0]   q_y;
  logic [REM_W-1:0]       r_x;
  logic [REM_W-1:0]       r_y;
  logic [STEP_W-1:0]      k_issue;
  logic                   chk_valid;
  logic [STEP_W-1:0]      chk_k;
  logic                   chk_oob;
  logic [KW-1:0]          res_k;
  logic                   res_hit;

  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic                   ram_wdata;
  logic                   ram_rdata;

  logic                   in_xfer;
  logic                   cell_ok;
  logic [ANG_PROD_W-1:0]  ang_prod;
  logic [ANGLE_W-1:0]     angle;
  logic [SINE_IDX_W-1:0]  idx_s;
  logic [SINE_IDX_W-1:0]  idx_c;
  logic [STEP_N_W-1:0]    n_x_c;
  logic [STEP_N_W-1:0]    n_y_c;
  logic [QD_W-1:0]        qd_x;
  logic [QD_W-1:0]        qd_y;
  logic [STEP_N_W-1:0]    rem_x;
  logic [STEP_N_W-1:0]    rem_y;
  logic signed [XW-1:0]   pos_x;
  logic signed [XW-1:0]   pos_y;
  logic [TXW-1:0]         tile_x;
  logic [TXW-1:0]         tile_y;
  logic                   oob;
  logic [AW-1:0]          march_addr;
  logic [REM_W:0]         rsum_x;
  logic [REM_W:0]         rsum_y;
  logic                   wrap_x;
  logic                   wrap_y;
  logic                   hit_now;
  logic                   done_now;
  logic                   out_load;
  logic signed [TOP_W-1:0] top_val;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cell_ok  = (32'(cell_index) < CELL_COUNT);

  // angle and table lookup
  assign ang_prod = ANG_PROD_W'(col_prod) * ANG_PROD_W'(COL_RECIP);
  assign angle    = view_angle - {1'b0, field_of_view[FOV_W-1:1]} + ang_off;
  assign idx_s    = angle[ANGLE_W-1 -: SINE_IDX_W];
  assign idx_c    = idx_s + SINE_IDX_W'(QUARTER_SIZE);

  // floor split of the direction by the step divisor
  assign n_x_c = STEP_N_W'(32'(ex) + STEP_BIAS);
  assign n_y_c = STEP_N_W'(32'(ey) + STEP_BIAS);
  assign qd_x  = prod_x[STEP_SHIFT +: QD_W];
  assign qd_y  = prod_y[STEP_SHIFT +: QD_W];
  assign rem_x = n_x - STEP_N_W'(qd_x * STEP_DIV);
  assign rem_y = n_y - STEP_N_W'(qd_y * STEP_DIV);

  // current march position and map cell
  assign pos_x  = $signed({{(XW-POS_W){1'b0}}, player_x}) + XW'(q_x);
  assign pos_y  = $signed({{(XW-POS_W){1'b0}}, player_y}) + XW'(q_y);
  assign tile_x = pos_x[XW-1:POS_FRAC];
  assign tile_y = pos_y[XW-1:POS_FRAC];
  assign oob    = tile_x[TXW-1] || (tile_x[TXW-2:0] >= (TXW-1)'(MAP_WIDTH))
               || tile_y[TXW-1] || (tile_y[TXW-2:0] >= (TXW-1)'(MAP_HEIGHT));
  assign march_addr = AW'(int'(tile_y[MYW-1:0]) * MAP_WIDTH + int'(tile_x[MXW-1:0]));

  assign rsum_x = {1'b0, r_x} + {1'b0, er_x};
  assign rsum_y = {1'b0, r_y} + {1'b0, er_y};
  assign wrap_x = (rsum_x >= (REM_W+1)'(STEP_DIV));
  assign wrap_y = (rsum_y >= (REM_W+1)'(STEP_DIV));

  assign hit_now  = chk_valid && (chk_oob || ram_rdata);
  assign done_now = chk_valid && (hit_now || chk_k == STEP_W'(MARCH_STEPS));
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);
  assign top_val  = $signed(WALL_TOP_ROM[res_k]);

  // map port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = march_addr;
    ram_wdata = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_IDLE: begin
        ram_we    = in_xfer && (cmd == CMD_WRITE) && cell_ok;
        ram_addr  = AW'(cell_index);
        ram_wdata = cell_is_wall;
      end
      default: begin
        ram_addr = march_addr;
      end
    endcase
  end

  grmc_ram #(
    .WIDTH(1),
    .DEPTH(CELL_COUNT)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == AW'(CELL_COUNT - 1)) state_next = S_IDLE;
      S_IDLE:   if (in_xfer && cmd == CMD_CAST) state_next = S_ANGLE;
      S_ANGLE:  state_next = S_SINE;
      S_SINE:   state_next = S_SPLIT;
      S_SPLIT:  state_next = S_SEED;
      S_SEED:   state_next = S_MARCH;
      S_MARCH:  if (done_now) state_next = S_FINISH;
      S_FINISH: if (out_load) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      chk_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_MARCH && !done_now) begin
        chk_valid <= 1'b1;
      end else begin
        chk_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= PLAYER_X_RESET;
      player_y      <= PLAYER_Y_RESET;
      view_angle    <= VIEW_ANGLE_RESET;
      field_of_view <= FIELD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PLAYER_X:   player_x      <= cfg_data;
        REG_PLAYER_Y:   player_y      <= cfg_data;
        REG_VIEW_ANGLE: view_angle    <= cfg_data;
        REG_FIELD:      field_of_view <= cfg_data[FOV_W-1:0];
        default:        player_x      <= player_x;
      endcase
    end
  end

  // cast datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      col      <= column;
      col_prod <= COL_PROD_W'(column) * COL_PROD_W'(field_of_view);
    end
    if (state == S_ANGLE) begin
      ang_off <= ang_prod[COL_SHIFT +: ANGLE_W];
    end
    if (state == S_SINE) begin
      ex <= trig_lookup(idx_s);
      ey <= trig_lookup(idx_c);
    end
    if (state == S_SPLIT) begin
      n_x    <= n_x_c;
      n_y    <= n_y_c;
      prod_x <= STEP_PROD_W'(n_x_c) * STEP_PROD_W'(STEP_RECIP);
      prod_y <= STEP_PROD_W'(n_y_c) * STEP_PROD_W'(STEP_RECIP);
    end
    if (state == S_SEED) begin
      eq_x    <= QW'($signed({1'b0, qd_x})) - QW'(STEP_BIAS_Q);
      eq_y    <= QW'($signed({1'b0, qd_y})) - QW'(STEP_BIAS_Q);
      er_x    <= rem_x[REM_W-1:0];
      er_y    <= rem_y[REM_W-1:0];
      q_x     <= QW'($signed({1'b0, qd_x})) - QW'(STEP_BIAS_Q);
      q_y     <= QW'($signed({1'b0, qd_y})) - QW'(STEP_BIAS_Q);
      r_x     <= rem_x[REM_W-1:0];
      r_y     <= rem_y[REM_W-1:0];
      k_issue <= STEP_W'(1);
    end
    if (state == S_MARCH) begin
      if (done_now) begin
        res_k   <= chk_k[KW-1:0];
        res_hit <= hit_now;
      end else begin
        chk_k   <= k_issue;
        chk_oob <= oob;
        k_issue <= k_issue + 1'b1;
        q_x     <= q_x + eq_x + QW'(wrap_x);
        q_y     <= q_y + eq_y + QW'(wrap_y);
        r_x     <= wrap_x ? REM_W'(rsum_x - (REM_W+1)'(STEP_DIV)) : rsum_x[REM_W-1:0];
        r_y     <= wrap_y ? REM_W'(rsum_y - (REM_W+1)'(STEP_DIV)) : rsum_y[REM_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_column  <= col;
      hit_steps   <= HIT_W'(res_k);
      hit_found   <= res_hit;
      wall_top    <= top_val;
      wall_bottom <= BOTTOM_W'(SCREEN_HEIGHT - int'(top_val));
      if (int'(res_k) < SHADE_MID_STEPS) begin
        shade <= SHADE_NEAR;
      end else if (int'(res_k) < SHADE_FAR_STEPS) begin
        shade <= SHADE_MID;
      end else begin
        shade <= SHADE_FAR;
      end
    end
  end

`ifndef SYNTHESIS
  a_map_quiet_in_march: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARCH) |-> !ram_we)
    else $error("map written during march");

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARCH) |-> (r_x < STEP_DIV && r_y < STEP_DIV))
    else $error("step remainder out of range");

  a_step_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARCH && chk_valid && $past(chk_valid))
      |-> (chk_k == STEP_W'($past(chk_k) + 1'b1)))
    else $error("march step skipped");

  a_range_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit_found) |-> (hit_steps == HIT_W'(MARCH_STEPS)))
    else $error("range exhausted before last step");
`endif

endmodule

`default_nettype wire
